// ===== rtl/gspc_pkg.sv =====
// Shared types, register codes and constant tables for the gas sensor ppm converter.
// Used by gspc_ctrl, gspc_dp, top level, checker and bench; depends on nothing else.

package gspc_pkg;

  // Default build values
  localparam int CONV_BITS_DEF = 12;
  localparam int CHANNELS_DEF = 2;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_RES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_RES   = 2'd2;

  localparam logic [8:0]  AVG_RESET = 9'd16;
  localparam logic [15:0] RL_RESET  = 16'd2560;
  localparam logic [15:0] R0_RESET  = 16'd2516;

  // Stream field widths
  localparam int SAMPLE_W = 12;
  localparam int IN_DATA_W = 16;
  localparam int LEVEL_W = 24;
  localparam int GASES = 4;
  localparam int OUT_DATA_W = LEVEL_W * GASES;
  localparam int OUT_USER_W = 2;

  // Fixed point widths
  localparam int LG_W = 21;   // signed Q5.16 log2 of the ratio
  localparam int LK_W = 21;
  localparam int EX_W = 19;
  localparam int GP_W = EX_W + LG_W;
  localparam int TW = 26;     // signed Q.16 exponent of a level

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // Per gas: log2 of the scale factor and the power, both Q.16
  localparam logic signed [LK_W-1:0] GAS_LOGK [GASES] = '{
    21'sd80567, 21'sd166710, 21'sd664227, 21'sd261471
  };
  localparam logic signed [EX_W-1:0] GAS_EXPO [GASES] = '{
    -19'sd261308, -19'sd23593, -19'sd24904, -19'sd27525
  };

  // Bitwise integer square root, used only on constants
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = x;
    res = '0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Q2.30 value of 2^(2^-k)
  function automatic logic [31:0] exp2_root(input int k);
    logic [63:0] t;
    t = 64'd1 << 31;
    for (int j = 1; j <= 16; j++) begin
      if (j <= k) begin
        t = isqrt64(t << 30);
      end
    end
    return t[31:0];
  endfunction

  localparam logic [31:0] EXP2_T [16] = '{
    exp2_root(1),  exp2_root(2),  exp2_root(3),  exp2_root(4),
    exp2_root(5),  exp2_root(6),  exp2_root(7),  exp2_root(8),
    exp2_root(9),  exp2_root(10), exp2_root(11), exp2_root(12),
    exp2_root(13), exp2_root(14), exp2_root(15), exp2_root(16)
  };

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE, OP_ACC, OP_MUL0, OP_MUL1, OP_DIVI, OP_DIV, OP_RSAT, OP_NORM,
    OP_SQM, OP_SQA, OP_GMUL, OP_GADD, OP_EXPM, OP_EXPA, OP_GFIN, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] gas;
    logic [3:0] step;
  } gspc_cmd_t;

  typedef struct packed {
    logic win_done;   // word being offered completes its window
    logic r_zero;     // ratio came out zero
    logic r_norm;     // ratio leading one sits in the top bit
    logic t_direct;   // level exponent out of range, level set directly
    logic out_free;   // output register can take a new word
  } gspc_sts_t;

endpackage

// ===== rtl/gspc_ctrl.sv =====
// Sequencer for the gas sensor ppm converter: steps the datapath through
// accumulate, divide, log2 and per-gas exp2. Depends on gspc_pkg.

module gspc_ctrl import gspc_pkg::*; #(
  parameter int CONV_BITS = CONV_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  gspc_sts_t sts,
  output gspc_cmd_t cmd
);

  localparam int NUMW = CONV_BITS + 8 + 32;
  localparam int DCW = $clog2(NUMW);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(NUMW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_DIVI, S_DIV, S_RSAT, S_NORM, S_SQM, S_SQA,
    S_GMUL, S_GADD, S_EXPM, S_EXPA, S_GFIN, S_OUT
  } state_t;

  state_t         state_r, state_nxt;
  logic [DCW-1:0] div_r, div_nxt;
  logic [3:0]     step_r, step_nxt;
  logic [1:0]     gas_r, gas_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    div_nxt = div_r;
    step_nxt = step_r;
    gas_nxt = gas_r;
    cmd.op = OP_IDLE;
    cmd.gas = gas_r;
    cmd.step = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = OP_ACC;
          if (sts.win_done) begin
            state_nxt = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        cmd.op = OP_MUL0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op = OP_MUL1;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.op = OP_DIVI;
        div_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        div_nxt = div_r + 1'b1;
        if (div_r == DIV_LAST) begin
          state_nxt = S_RSAT;
        end
      end
      S_RSAT: begin
        cmd.op = OP_RSAT;
        state_nxt = sts.r_zero ? S_OUT : S_NORM;
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        step_nxt = '0;
        if (sts.r_norm) begin
          state_nxt = S_SQM;
        end
      end
      S_SQM: begin
        cmd.op = OP_SQM;
        state_nxt = S_SQA;
      end
      S_SQA: begin
        cmd.op = OP_SQA;
        step_nxt = step_r + 1'b1;
        gas_nxt = '0;
        state_nxt = (step_r == 4'hF) ? S_GMUL : S_SQM;
      end
      S_GMUL: begin
        cmd.op = OP_GMUL;
        state_nxt = S_GADD;
      end
      S_GADD: begin
        cmd.op = OP_GADD;
        step_nxt = '0;
        if (sts.t_direct) begin
          gas_nxt = gas_r + 1'b1;
          state_nxt = (gas_r == 2'd3) ? S_OUT : S_GMUL;
        end else begin
          state_nxt = S_EXPM;
        end
      end
      S_EXPM: begin
        cmd.op = OP_EXPM;
        state_nxt = S_EXPA;
      end
      S_EXPA: begin
        cmd.op = OP_EXPA;
        step_nxt = step_r + 1'b1;
        state_nxt = (step_r == 4'hF) ? S_GFIN : S_EXPM;
      end
      S_GFIN: begin
        cmd.op = OP_GFIN;
        gas_nxt = gas_r + 1'b1;
        state_nxt = (gas_r == 2'd3) ? S_OUT : S_GMUL;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  // Hold state and loop counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      div_r <= '0;
      step_r <= '0;
      gas_r <= '0;
    end else begin
      state_r <= state_nxt;
      div_r <= div_nxt;
      step_r <= step_nxt;
      gas_r <= gas_nxt;
    end
  end

endmodule

// ===== rtl/gspc_dp.sv =====
// Datapath of the gas sensor ppm converter: per-channel sums, config registers,
// long divider, log2 by squaring, exp2 by root table and the output register.
// Depends on gspc_pkg.

module gspc_dp import gspc_pkg::*; #(
  parameter int CONV_BITS = CONV_BITS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_channel,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  input  gspc_cmd_t             cmd,
  output gspc_sts_t             sts
);

  localparam int SW = CONV_BITS + 8;
  localparam int DENW = SW + 16;
  localparam int NUMW = DENW + 16;
  localparam logic [SW-1:0] FS = SW'((1 << CONV_BITS) - 1);
  localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((1 << CONV_BITS) - 1);
  localparam logic signed [TW-1:0] T_BIAS = TW'(8 << 16);
  localparam logic signed [TW-1:0] T_TOP = TW'(24 << 16);

  // Configuration registers
  logic [8:0]  avg_r;
  logic [15:0] rl_r;
  logic [15:0] r0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= AVG_RESET;
      rl_r <= RL_RESET;
      r0_r <= R0_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AVG_COUNT: avg_r <= cfg_data[8:0];
        CFG_LOAD_RES:  rl_r <= cfg_data;
        CFG_AIR_RES:   r0_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-channel accumulation
  logic [SW-1:0] sum_r [CHANNELS];
  logic [8:0]    cnt_r [CHANNELS];
  logic [SW-1:0] sum_cur, sum_new;
  logic [8:0]    cnt_cur, cnt_new, limit;
  logic          ch_ok;

  always_comb begin
    sum_cur = '0;
    cnt_cur = '0;
    ch_ok = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c == int'(in_channel)) begin
        sum_cur = sum_r[c];
        cnt_cur = cnt_r[c];
        ch_ok = 1'b1;
      end
    end
    if (avg_r == 9'd0) begin
      limit = 9'd1;
    end else if (avg_r > 9'd256) begin
      limit = 9'd256;
    end else begin
      limit = avg_r;
    end
    sum_new = sum_cur + SW'(in_sample & SMASK);
    cnt_new = cnt_cur + 9'd1;
  end

  assign sts.win_done = ch_ok && (cnt_new >= limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum_r[c] <= '0;
        cnt_r[c] <= '0;
      end
    end else if (cmd.op == OP_ACC) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (c == int'(in_channel)) begin
          sum_r[c] <= sts.win_done ? '0 : sum_new;
          cnt_r[c] <= sts.win_done ? '0 : cnt_new;
        end
      end
    end
  end

  // Window, ratio and log2 registers
  logic [8:0]       n_r;
  logic [SW-1:0]    s_r;
  logic             ch_r;
  logic             clamp_r;
  logic [SW-1:0]    fn_r;
  logic [DENW-1:0]  den_r;
  logic [DENW-1:0]  numm_r;
  logic [NUMW-1:0]  numsh_r;
  logic [DENW:0]    rem_r;
  logic [31:0]      q_r;
  logic             qsat_r;
  logic [31:0]      r_r;
  logic [4:0]       nsh_r;
  logic [30:0]      m_r;
  logic [61:0]      sq_r;
  logic [15:0]      frac_r;
  logic signed [GP_W-1:0] gp_r;
  logic [15:0]      tfrac_r;
  logic [4:0]       ip_r;
  logic [31:0]      v_r;
  logic [63:0]      vp_r;
  logic [LEVEL_W-1:0] level_r [GASES];

  // Division step, ratio select and exponent of the current gas
  logic [DENW:0]          trial;
  logic                   ge;
  logic [31:0]            r_sel;
  logic [31:0]            sq_top;
  logic signed [4:0]      lg_int;
  logic signed [LG_W-1:0] lg;
  logic signed [TW-1:0]   t_c;
  logic [4:0]             sh;
  logic [31:0]            vs;

  always_comb begin
    trial = {rem_r[DENW-1:0], numsh_r[NUMW-1]};
    ge = trial >= {1'b0, den_r};
    // Zero sum clamps high, then a zero numerator wins over a zero divisor
    r_sel = clamp_r ? 32'hFFFF_FFFF :
            (numm_r == '0) ? 32'd0 :
            qsat_r ? 32'hFFFF_FFFF : q_r;
    sq_top = sq_r[61:30];
    lg_int = signed'(5'd15 - nsh_r);
    lg = signed'({lg_int, frac_r});
    t_c = TW'(GAS_LOGK[cmd.gas]) + TW'(gp_r >>> 16) + T_BIAS;
    sh = 5'd30 - ip_r;
    vs = v_r >> sh;
  end

  assign sts.r_zero = (r_sel == 32'd0);
  assign sts.r_norm = r_r[31];
  assign sts.t_direct = (t_c >= T_TOP) || (t_c < 0);

  // Sequenced arithmetic
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACC: begin
        n_r <= cnt_new;
        s_r <= sum_new;
        ch_r <= in_channel;
      end
      OP_MUL0: begin
        fn_r <= SW'(FS * n_r);
        den_r <= DENW'(s_r * r0_r);
        clamp_r <= (s_r == '0);
      end
      OP_MUL1: begin
        numm_r <= DENW'((fn_r - s_r) * rl_r);
      end
      OP_DIVI: begin
        numsh_r <= {numm_r, 16'd0};
        rem_r <= '0;
        q_r <= '0;
        qsat_r <= 1'b0;
      end
      OP_DIV: begin
        rem_r <= ge ? (trial - {1'b0, den_r}) : trial;
        numsh_r <= {numsh_r[NUMW-2:0], 1'b0};
        q_r <= {q_r[30:0], ge};
        qsat_r <= qsat_r | q_r[31];
      end
      OP_RSAT: begin
        r_r <= r_sel;
        nsh_r <= '0;
        if (r_sel == 32'd0) begin
          for (int g = 0; g < GASES; g++) begin
            level_r[g] <= LEVEL_MAX;
          end
        end
      end
      OP_NORM: begin
        if (r_r[31]) begin
          m_r <= r_r[31:1];
          frac_r <= '0;
        end else begin
          r_r <= {r_r[30:0], 1'b0};
          nsh_r <= nsh_r + 5'd1;
        end
      end
      OP_SQM: begin
        sq_r <= m_r * m_r;
      end
      OP_SQA: begin
        m_r <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
        frac_r <= {frac_r[14:0], sq_top[31]};
      end
      OP_GMUL: begin
        gp_r <= GAS_EXPO[cmd.gas] * lg;
      end
      OP_GADD: begin
        if (t_c >= T_TOP) begin
          level_r[cmd.gas] <= LEVEL_MAX;
        end else if (t_c < 0) begin
          level_r[cmd.gas] <= '0;
        end
        tfrac_r <= t_c[15:0];
        ip_r <= t_c[20:16];
        v_r <= 32'd1 << 30;
      end
      OP_EXPM: begin
        vp_r <= v_r * EXP2_T[cmd.step];
      end
      OP_EXPA: begin
        if (tfrac_r[~cmd.step]) begin
          v_r <= vp_r[61:30];
        end
      end
      OP_GFIN: begin
        level_r[cmd.gas] <= (vs > 32'(LEVEL_MAX)) ? LEVEL_MAX : vs[LEVEL_W-1:0];
      end
      default: ;
    endcase
  end

  // Output register: hold the word until taken
  logic out_valid_r;

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_tdata <= {level_r[3], level_r[2], level_r[1], level_r[0]};
      out_tuser <= {clamp_r, ch_r};
    end
  end

endmodule

// ===== rtl/gas_sensor_ppm_converter_unit.sv =====
// Top level of the gas sensor ppm converter: controller plus datapath.
// Depends on gspc_pkg, gspc_ctrl and gspc_dp.

// Samples tagged with a channel are summed per channel; a sample that does not
// complete its channel's window is taken while the unit stays idle. The sample
// that completes a window starts the conversion, and no new sample is taken
// until its result is in the output register. The conversion runs the
// bit-serial long divider (one quotient bit a cycle over CONV_BITS+40 bits), the
// leading-one shifter, 16 squarings for log2 and, for each of four gases, 16
// multiplies by the exp2 root table; a gas whose level is out of range skips
// those multiplies. A zero result ratio skips log2 and exp2. If the previous
// word still waits in the output register, the new one waits until it is taken.
// The finished word waits in the output register while the next samples are
// taken.

module gas_sensor_ppm_converter_unit import gspc_pkg::*; #(
  parameter int CONV_BITS = CONV_BITS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample[11:0], zero pad
  input  logic                  in_tuser,   // channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // benzene, co, co2, smoke levels
  output logic [OUT_USER_W-1:0] out_tuser   // result_channel, resistance_clamped
);

  gspc_cmd_t cmd;
  gspc_sts_t sts;

  gspc_ctrl #(
    .CONV_BITS (CONV_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gspc_dp #(
    .CONV_BITS (CONV_BITS),
    .CHANNELS  (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_channel (in_tuser),
    .in_sample  (in_tdata[SAMPLE_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== rtl/gspc_checker.sv =====
// Port-level checks for the gas sensor ppm converter, bound to the top level.
// Depends on gspc_pkg.

module gspc_checker import gspc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // Stalled word stays valid
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // Stalled word holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // Reset empties the output register
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A word never appears right after an input; the conversion runs in between
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result shown one cycle after a sample");

endmodule

bind gas_sensor_ppm_converter_unit gspc_checker u_gspc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/tb_gas_sensor_ppm_converter_unit.sv =====
// Self-checking bench for gas_sensor_ppm_converter_unit: drives tagged ADC words,
// predicts each window result in fixed point and compares it with the output word.
// Depends on gspc_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb_gas_sensor_ppm_converter_unit;
  import gspc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int FULL_SCALE     = 4095;

  typedef struct packed {
    logic        chan;
    logic        clamp;
    logic [23:0] smoke;
    logic [23:0] co2;
    logic [23:0] co;
    logic [23:0] benzene;
  } level_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // sample[11:0], zero pad
  logic                  in_tuser;   // channel
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // benzene, co, co2, smoke levels
  logic [OUT_USER_W-1:0] out_tuser;  // result_channel, resistance_clamped

  // Predictor state: per-channel window sums, counts and the register copies
  longint unsigned win_sum [2];
  longint unsigned win_cnt [2];
  longint unsigned avg_reg, rl_reg, r0_reg;
  longint unsigned exp_root [1:16];
  level_word_t     level_q [$];

  int  mismatches;
  int  idle_cycles;
  int  ready_hold;
  bit  no_gaps;

  gas_sensor_ppm_converter_unit i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned rem, res, bt;
    rem = x;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // log2 of a Q16.16 ratio, signed Q.16
  function automatic longint ratio_log2(longint unsigned r);
    int p;
    longint unsigned m;
    longint frac;
    p = 31;
    frac = 0;
    while (r[p] == 1'b0) p--;
    if (p >= 30) m = r >> (p - 30);
    else m = r << (30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(p - 16) * 65536 + frac;
  endfunction

  function automatic logic [23:0] gas_ppm(longint lg, int g);
    longint t;
    longint unsigned v;
    int ip;
    t = longint'(GAS_LOGK[g]) + ((longint'(GAS_EXPO[g]) * lg) >>> 16) + 8 * 65536;
    if (t >= 24 * 65536) return LEVEL_MAX;
    if (t < 0) return '0;
    ip = int'(t >>> 16);
    v = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if (t[16-k]) v = (v * exp_root[k]) >> 30;
    v = v >> (30 - ip);
    return (v > 64'hFFFFFF) ? LEVEL_MAX : v[23:0];
  endfunction

  // Accumulate one word; return 1 with the window result when it completes
  function automatic bit window_update(input logic ch, input logic [11:0] smp,
                                       output level_word_t w);
    longint unsigned lim, n, s, r, num, den;
    longint lg;
    lim = avg_reg;
    if (lim == 0) lim = 1;
    if (lim > 256) lim = 256;
    win_sum[ch] += smp;
    win_cnt[ch] += 1;
    w = '0;
    if (win_cnt[ch] < lim) return 0;
    n = win_cnt[ch];
    s = win_sum[ch];
    win_sum[ch] = 0;
    win_cnt[ch] = 0;
    w.chan = ch;
    if (s == 0) begin
      w.clamp = 1'b1;
      r = 64'hFFFFFFFF;
    end else begin
      num = ((FULL_SCALE * n - s) * rl_reg) << 16;
      den = s * r0_reg;
      if (num == 0) r = 0;
      else if (den == 0) r = 64'hFFFFFFFF;
      else begin
        r = num / den;
        if (r > 64'hFFFFFFFF) r = 64'hFFFFFFFF;
      end
    end
    if (r == 0) begin
      {w.smoke, w.co2, w.co, w.benzene} = {4{LEVEL_MAX}};
    end else begin
      lg = ratio_log2(r);
      w.benzene = gas_ppm(lg, 0);
      w.co      = gas_ppm(lg, 1);
      w.co2     = gas_ppm(lg, 2);
      w.smoke   = gas_ppm(lg, 3);
    end
    return 1;
  endfunction

  // Wait out every pending result plus the conversion latency, then write all registers
  task automatic set_regs(input logic [15:0] avg, input logic [15:0] rl,
                          input logic [15:0] r0);
    in_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AVG_COUNT; cfg_data <= avg;
    @(posedge clk);
    cfg_index <= CFG_LOAD_RES; cfg_data <= rl;
    @(posedge clk);
    cfg_index <= CFG_AIR_RES; cfg_data <= r0;
    @(posedge clk);
    cfg_we <= 1'b0;
    avg_reg = avg & 16'h1FF;
    rl_reg = rl;
    r0_reg = r0;
  endtask

  // Send one word and predict its effect once accepted
  task automatic send_sample(input logic ch, input logic [11:0] smp);
    int gap;
    level_word_t w;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, smp};
    in_tuser <= ch;
    do @(posedge clk); while (!in_tready);
    if (window_update(ch, smp, w)) level_q.push_back(w);
  endtask

  function automatic logic [11:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'($urandom_range(4000, 4095));
      3: return 12'($urandom_range(0, 60));
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_res();
    case ($urandom_range(0, 4))
      0: return 16'd1;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(256, 16'hFFFF));
    endcase
  endfunction

  // Power-on defaults: one window of sixteen words
  task automatic test_reset_defaults();
    for (int i = 0; i < 16; i++) send_sample(1'b0, 12'd2048 + 12'(i));
  endtask

  // Zero sum, full scale, tiny and huge ratios, zero RL and zero R0
  task automatic test_corner_windows();
    set_regs(16'd1, 16'd2560, 16'd2516);
    send_sample(1'b0, 12'd0);
    send_sample(1'b1, 12'd4095);
    send_sample(1'b1, 12'd1);
    send_sample(1'b0, 12'd4094);
    set_regs(16'd1, 16'd0, 16'd2516);
    send_sample(1'b0, 12'd100);
    set_regs(16'd1, 16'd100, 16'd0);
    send_sample(1'b1, 12'd100);
    set_regs(16'd1, 16'hFFFF, 16'd1);
    send_sample(1'b0, 12'd1);
    set_regs(16'd1, 16'd1, 16'hFFFF);
    send_sample(1'b1, 12'd4094);
  endtask

  // Window size zero acts as one; oversize acts as 256; lowering mid-window completes it
  task automatic test_window_limits();
    set_regs(16'd0, 16'd2560, 16'd2516);
    send_sample(1'b0, 12'd1000);
    send_sample(1'b1, 12'd3000);
    set_regs(16'hFFFF, 16'd2560, 16'd2516);
    for (int i = 0; i < 5; i++) send_sample(1'b1, 12'd500 * 12'(i));
    set_regs(16'd2, 16'd2560, 16'd2516);
    send_sample(1'b1, 12'd777);
  endtask

  // Random phases with random registers, mostly short windows
  task automatic test_random_windows();
    logic [15:0] avg;
    for (int ph = 0; ph < 8; ph++) begin
      avg = 16'($urandom_range(1, 5));
      set_regs(avg, rand_res(), rand_res());
      no_gaps = (ph % 3 == 2);
      for (int i = 0; i < 15; i++) send_sample(1'($urandom), rand_sample());
    end
    no_gaps = 1'b0;
  endtask

  // Largest window on one channel
  task automatic test_full_window();
    set_regs(16'd256, 16'($urandom), 16'($urandom_range(1, 16'hFFFF)));
    for (int i = 0; i < 256; i++) send_sample(1'b0, 12'($urandom));
  endtask

  // Result side: random back-pressure and comparison against the oldest prediction
  always @(posedge clk) begin
    level_word_t w, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tuser[1], out_tdata};
        if (level_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected word: %h", got);
        end else begin
          w = level_q.pop_front();
          if (got !== w) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: chan %0b/%0b clamp %0b/%0b benz %h/%h",
                        " co %h/%h co2 %h/%h smoke %h/%h"},
                       w.chan, got.chan, w.clamp, got.clamp, w.benzene, got.benzene,
                       w.co, got.co, w.co2, got.co2, w.smoke, got.smoke);
          end
        end
        ready_hold = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    longint unsigned t;
    t = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      t = int_sqrt(t << 30);
      exp_root[k] = t;
    end
    win_sum = '{0, 0};
    win_cnt = '{0, 0};
    avg_reg = 16;
    rl_reg = 2560;
    r0_reg = 2516;
    mismatches = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_AVG_COUNT;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_corner_windows();
    test_window_limits();
    test_random_windows();
    test_full_window();

    in_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
